FILE: rtl/kpsr_pkg.sv
// kpsr_pkg: shared types and constants for the k-th present select and remove block
// no dependencies
`default_nettype none
package kpsr_pkg;
	localparam int unsigned MAX_SLOTS_DEF = 1024;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned RANK_W = 11;
	localparam int unsigned SLOT_OUT_W = 10;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef enum logic {
		ST_OK = 1'b0,
		ST_RANGE = 1'b1
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CLEAR,
		BK_DESC,
		BK_UPD,
		BK_READ,
		BK_OUT
	} back_state_t;
endpackage
`default_nettype wire

FILE: rtl/kpsr_front.sv
// kpsr_front: accepts words and holds them in a small two-entry queue
// no dependencies
`default_nettype none
module kpsr_front #(
	parameter int unsigned QW = 44
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [QW-1:0] in_word,
	output logic q_valid,
	input wire logic q_pop,
	output logic [QW-1:0] q_word
);
	// two-entry queue
	logic [QW-1:0] mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop && q_valid)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

`ifndef SYNTH
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count broken");
`endif
endmodule
`default_nettype wire

FILE: rtl/kpsr_back.sv
// kpsr_back: count tree memory, value memory and the descend/update sequencer
// depends on kpsr_pkg
`default_nettype none
module kpsr_back #(
	parameter int unsigned MAX_SLOTS = kpsr_pkg::MAX_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [kpsr_pkg::LEN_W-1:0] list_length,
	input wire logic cmd_valid,
	output logic cmd_pop,
	input wire logic cmd_action,
	input wire logic [kpsr_pkg::WORD_W-1:0] cmd_value,
	input wire logic [kpsr_pkg::RANK_W-1:0] cmd_rank,
	output logic out_valid,
	input wire logic out_ready,
	output logic [kpsr_pkg::WORD_W-1:0] removed_value,
	output logic [kpsr_pkg::SLOT_OUT_W-1:0] removed_slot,
	output logic status
);
	localparam int unsigned LV = (MAX_SLOTS <= 2) ? 1 : $clog2(MAX_SLOTS);
	localparam int unsigned LEAVES = 1 << LV;
	localparam int unsigned NODES = 2 * LEAVES;
	localparam int unsigned NW = LV + 1;
	localparam int unsigned CW = LV + 1;
	localparam int unsigned PW = LV + 1;
	localparam int unsigned SW = (LV > kpsr_pkg::SLOT_OUT_W) ? LV : kpsr_pkg::SLOT_OUT_W;
	// rank register wide enough for both the rank field and a count
	localparam int unsigned KW = (CW > kpsr_pkg::RANK_W) ? CW : kpsr_pkg::RANK_W;

	logic [CW-1:0] tree_mem [NODES];
	logic [kpsr_pkg::WORD_W-1:0] val_mem [LEAVES];

	kpsr_pkg::back_state_t st_q, st_d;
	logic [NW-1:0] node_q, node_d;
	logic [KW-1:0] k_q, k_d;
	logic [LV:0] lvl_q, lvl_d;
	logic [PW-1:0] lp_q, lp_d;
	logic del_q, del_d;
	logic [LV-1:0] slot_q, slot_d;
	logic first_q, first_d;

	// tree port: one read (registered) and one write per cycle
	logic [NW-1:0] rd_addr;
	logic [CW-1:0] rd_data_q;
	logic t_we;
	logic [NW-1:0] t_waddr;
	logic [CW-1:0] t_wdata;
	logic v_we;
	logic [kpsr_pkg::WORD_W-1:0] v_rdata_q;

	logic [kpsr_pkg::WORD_W-1:0] ov_q;
	logic [kpsr_pkg::SLOT_OUT_W-1:0] os_q;
	logic ost_q, ovld_q;
	logic [kpsr_pkg::WORD_W-1:0] ov_d;
	logic [kpsr_pkg::SLOT_OUT_W-1:0] os_d;
	logic ost_d, ovld_d;
	logic [PW:0] limit;
	logic [SW-1:0] slot_ext;

	always_ff @(posedge clk) begin
		rd_data_q <= tree_mem[rd_addr];
		if (t_we)
			tree_mem[t_waddr] <= t_wdata;
		if (v_we)
			val_mem[lp_q[LV-1:0]] <= cmd_value;
		v_rdata_q <= val_mem[slot_q];
	end

	always_comb begin
		if (32'(list_length) > 32'(MAX_SLOTS))
			limit = (PW+1)'(MAX_SLOTS);
		else
			limit = (PW+1)'(list_length);
	end

	assign slot_ext = SW'(slot_q);

	always_comb begin
		st_d = st_q;
		node_d = node_q;
		k_d = k_q;
		lvl_d = lvl_q;
		lp_d = lp_q;
		del_d = del_q;
		slot_d = slot_q;
		first_d = first_q;
		cmd_pop = 1'b0;
		rd_addr = NW'(1);
		t_we = 1'b0;
		t_waddr = node_q;
		t_wdata = '0;
		v_we = 1'b0;
		ov_d = ov_q;
		os_d = os_q;
		ost_d = ost_q;
		ovld_d = ovld_q && !out_ready;
		unique case (st_q)
			kpsr_pkg::BK_CLEAR: begin
				// clearing pass over the count tree after reset
				t_we = 1'b1;
				t_waddr = node_q;
				node_d = node_q + NW'(1);
				if (node_q == NW'(NODES-1))
					st_d = kpsr_pkg::BK_IDLE;
			end
			kpsr_pkg::BK_IDLE: begin
				rd_addr = NW'(1);
				if (cmd_valid && !ovld_q) begin
					cmd_pop = 1'b1;
					if (cmd_action == kpsr_pkg::ACT_LOAD) begin
						if ({1'b0, lp_q} < limit) begin
							v_we = 1'b1;
							t_we = 1'b1;
							t_waddr = NW'(LEAVES) + NW'(lp_q);
							t_wdata = CW'(1);
							node_d = (NW'(LEAVES) + NW'(lp_q)) >> 1;
							slot_d = lp_q[LV-1:0];
							lp_d = lp_q + PW'(1);
							del_d = 1'b0;
							first_d = 1'b1;
							st_d = kpsr_pkg::BK_UPD;
						end
					end else begin
						k_d = KW'(cmd_rank);
						node_d = NW'(1);
						lvl_d = '0;
						st_d = kpsr_pkg::BK_DESC;
						first_d = 1'b1;
					end
				end
			end
			kpsr_pkg::BK_DESC: begin
				// first cycle checks root, then one level per read
				rd_addr = {node_q[NW-2:0], 1'b0};
				if (first_q) begin
					first_d = 1'b0;
					if (k_q == '0 || k_q > KW'(rd_data_q)) begin
						ov_d = '0;
						os_d = '0;
						ost_d = kpsr_pkg::ST_RANGE;
						ovld_d = 1'b1;
						st_d = kpsr_pkg::BK_IDLE;
					end
				end else begin
					if (k_q <= KW'(rd_data_q)) begin
						node_d = {node_q[NW-2:0], 1'b0};
					end else begin
						k_d = k_q - KW'(rd_data_q);
						node_d = {node_q[NW-2:0], 1'b1};
					end
					// fetch the left child of the node just chosen
					rd_addr = {node_d[NW-2:0], 1'b0};
					lvl_d = lvl_q + (LV+1)'(1);
					if (lvl_q == (LV+1)'(LV-1)) begin
						st_d = kpsr_pkg::BK_READ;
					end
				end
			end
			kpsr_pkg::BK_READ: begin
				// clamp and clear the leaf
				slot_d = node_q[LV-1:0];
				if (node_q[LV-1:0] >= LV'(MAX_SLOTS-1) && MAX_SLOTS < LEAVES)
					slot_d = LV'(MAX_SLOTS-1);
				t_we = 1'b1;
				t_waddr = NW'(LEAVES) + NW'(slot_d);
				t_wdata = '0;
				node_d = (NW'(LEAVES) + NW'(slot_d)) >> 1;
				del_d = 1'b1;
				first_d = 1'b1;
				st_d = kpsr_pkg::BK_UPD;
			end
			kpsr_pkg::BK_UPD: begin
				// walk up: read left child, then read right and write sum
				if (first_q) begin
					rd_addr = {node_q[NW-2:0], 1'b0};
					first_d = 1'b0;
				end else begin
					rd_addr = {node_q[NW-2:0], 1'b1};
					k_d = KW'(rd_data_q);
					st_d = kpsr_pkg::BK_OUT;
				end
			end
			kpsr_pkg::BK_OUT: begin
				t_we = 1'b1;
				t_waddr = node_q;
				t_wdata = CW'(k_q) + rd_data_q;
				if (node_q == NW'(1)) begin
					if (del_q) begin
						ov_d = v_rdata_q;
						os_d = kpsr_pkg::SLOT_OUT_W'(slot_ext);
						ost_d = kpsr_pkg::ST_OK;
						ovld_d = 1'b1;
					end
					st_d = kpsr_pkg::BK_IDLE;
				end else begin
					node_d = node_q >> 1;
					first_d = 1'b1;
					st_d = kpsr_pkg::BK_UPD;
				end
			end
			default: st_d = kpsr_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= kpsr_pkg::BK_CLEAR;
			node_q <= '0;
			lp_q <= '0;
			ovld_q <= 1'b0;
			first_q <= 1'b0;
			del_q <= 1'b0;
		end else begin
			st_q <= st_d;
			node_q <= node_d;
			lp_q <= lp_d;
			ovld_q <= ovld_d;
			first_q <= first_d;
			del_q <= del_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d;
		lvl_q <= lvl_d;
		slot_q <= slot_d;
		ov_q <= ov_d;
		os_q <= os_d;
		ost_q <= ost_d;
	end

	assign out_valid = ovld_q;
	assign removed_value = ov_q;
	assign removed_slot = os_q;
	assign status = ost_q;

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(removed_value))
		else $error("result dropped");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> st_q == kpsr_pkg::BK_IDLE) else $error("pop while busy");
	a_lp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, lp_q} <= (PW+1)'(MAX_SLOTS)) else $error("load pointer overrun");
`endif
endmodule
`default_nettype wire

FILE: rtl/kth_present_select_and_remove.sv
// kth_present_select_and_remove: top level, front queue plus tree sequencer
// depends on kpsr_pkg, kpsr_front, kpsr_back
`default_nettype none
// Loads store a word in the next slot, while below the list length, and mark it
// present; removes find the k-th present slot by descending a count tree held in
// one memory, one level per cycle. After reset a clearing pass over every tree
// node runs before any word is taken from the queue. Load and remove time is set
// by the walk up the tree with one read port; an out-of-range remove ends after
// the root check. A two-word queue in front keeps input accepted while the
// sequencer works until the queue is full, and the result register holds one word.
module kth_present_select_and_remove #(
	parameter int unsigned MAX_SLOTS = kpsr_pkg::MAX_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [kpsr_pkg::LEN_W-1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic action,
	input wire logic [kpsr_pkg::WORD_W-1:0] element_value,
	input wire logic [kpsr_pkg::RANK_W-1:0] rank,
	output logic out_valid,
	input wire logic out_ready,
	output logic [kpsr_pkg::WORD_W-1:0] removed_value,
	output logic [kpsr_pkg::SLOT_OUT_W-1:0] removed_slot,
	output logic status
);
	localparam int unsigned QW = 1 + kpsr_pkg::WORD_W + kpsr_pkg::RANK_W;

	logic [kpsr_pkg::LEN_W-1:0] len_q;
	logic q_valid, q_pop;
	logic [QW-1:0] q_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_q <= kpsr_pkg::LEN_W'(1024);
		else if (cfg_we)
			len_q <= cfg_wdata;
	end

	kpsr_front #(.QW(QW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_word({action, element_value, rank}),
		.q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
	);

	kpsr_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .list_length(len_q),
		.cmd_valid(q_valid), .cmd_pop(q_pop),
		.cmd_action(q_word[QW-1]),
		.cmd_value(q_word[QW-2:kpsr_pkg::RANK_W]),
		.cmd_rank(q_word[kpsr_pkg::RANK_W-1:0]),
		.out_valid(out_valid), .out_ready(out_ready),
		.removed_value(removed_value), .removed_slot(removed_slot), .status(status)
	);
endmodule
`default_nettype wire
